FILE: rtl/cau_pkg.sv
// Package for the complex arithmetic unit: default widths, command and status codes,
// and the control bundle that travels with each beat. No dependencies.
`default_nettype none
package cau_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int IO_WIDTH       = 32;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/cau_if.sv
// Valid/ready channel interfaces for operand and result beats.
// Depends on cau_pkg for the fixed field width.
`default_nettype none
interface cau_op_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             command;
	logic signed [cau_pkg::IO_WIDTH-1:0]    a_real;
	logic signed [cau_pkg::IO_WIDTH-1:0]    a_imag;
	logic signed [cau_pkg::IO_WIDTH-1:0]    b_real;
	logic signed [cau_pkg::IO_WIDTH-1:0]    b_imag;
	modport source (output valid, command, a_real, a_imag, b_real, b_imag, input ready);
	modport sink (input valid, command, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_res_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [cau_pkg::IO_WIDTH-1:0]    out_real;
	logic signed [cau_pkg::IO_WIDTH-1:0]    out_imag;
	logic [1:0]                             status;
	modport source (output valid, out_real, out_imag, status, input ready);
	modport sink (input valid, out_real, out_imag, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: front stages, divider chain, result stage.
// Depends on cau_pkg, cau_if, cau_front, cau_div_step, cau_back.
//
//   channel  dir  fields                                   beat when
//   op       in   command, a_real, a_imag, b_real, b_imag  op.valid && op.ready
//   res      out  out_real, out_imag, status               res.valid && res.ready
//
// One beat enters per cycle while the output is not stalled; a beat passes through the
// three front stages, one divider stage per quotient bit, and the output register.
// Reset clears all valid bits. A stalled output freezes every stage at once
// through a common enable, so no beat is lost or repeated.
`default_nettype none
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	cau_op_if.sink    op,
	cau_res_if.source res
);
	localparam int W  = DATA_WIDTH;
	localparam int RW = 3 * W + FRAC_BITS + 1;
	localparam int SW = 2 * W + 6;

	logic en;

	cau_pkg::ctrl_t ctrl_p [0:W];
	logic [RW-1:0]  rem_re_p [0:W];
	logic [RW-1:0]  rem_im_p [0:W];
	logic [W-1:0]   q_re_p [0:W];
	logic [W-1:0]   q_im_p [0:W];
	logic [RW-1:0]  den_p [0:W];
	logic [SW-1:0]  side_p [0:W];

	assign q_re_p[0] = '0;
	assign q_im_p[0] = '0;

	cau_front #(.W(W), .F(FRAC_BITS), .RW(RW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.op        (op),
		.ctrl_s3   (ctrl_p[0]),
		.rem_re_s3 (rem_re_p[0]),
		.rem_im_s3 (rem_im_p[0]),
		.den_s3    (den_p[0]),
		.side_s3   (side_p[0])
	);

	for (genvar k = 0; k < W; k++) begin : g_div
		cau_div_step #(.W(W), .RW(RW), .STEP(W - 1 - k), .SW(SW)) u_step (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (en),
			.prev_ctrl   (ctrl_p[k]),
			.prev_rem_re (rem_re_p[k]),
			.prev_rem_im (rem_im_p[k]),
			.prev_q_re   (q_re_p[k]),
			.prev_q_im   (q_im_p[k]),
			.prev_den    (den_p[k]),
			.prev_side   (side_p[k]),
			.ctrl_s1     (ctrl_p[k+1]),
			.rem_re_s1   (rem_re_p[k+1]),
			.rem_im_s1   (rem_im_p[k+1]),
			.q_re_s1     (q_re_p[k+1]),
			.q_im_s1     (q_im_p[k+1]),
			.den_s1      (den_p[k+1]),
			.side_s1     (side_p[k+1])
		);
	end

	cau_back #(.W(W), .SW(SW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.prev_ctrl (ctrl_p[W]),
		.prev_q_re (q_re_p[W]),
		.prev_q_im (q_im_p[W]),
		.prev_side (side_p[W]),
		.en        (en),
		.res       (res)
	);
endmodule
`default_nettype wire

FILE: rtl/cau_front.sv
// Front stages: products, sums, rounding and saturation of add/multiply results,
// and divider setup. Depends on cau_pkg and cau_op_if.
`default_nettype none
module cau_front #(
	parameter int W  = cau_pkg::DATA_WIDTH_DEF,
	parameter int F  = cau_pkg::FRAC_BITS_DEF,
	parameter int RW = 3 * W + F + 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	cau_op_if.sink                 op,
	output cau_pkg::ctrl_t         ctrl_s3,
	output logic [RW-1:0]          rem_re_s3,
	output logic [RW-1:0]          rem_im_s3,
	output logic [RW-1:0]          den_s3,
	output logic [2*W+5:0]         side_s3
);
	localparam int PW = 2 * W;
	localparam int NW = 2 * W + 1;
	localparam int XW = 2 * W + 2;

	localparam logic signed [XW-1:0] MAXV = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] MINV = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

	function automatic logic ovf(input logic signed [XW-1:0] v);
		return (v > MAXV) || (v < MINV);
	endfunction

	function automatic logic [W-1:0] clip(input logic signed [XW-1:0] v);
		logic [W-1:0] r;
		if (v > MAXV) begin
			r = MAXV[W-1:0];
		end else if (v < MINV) begin
			r = MINV[W-1:0];
		end else begin
			r = v[W-1:0];
		end
		return r;
	endfunction

	logic signed [W-1:0] ar, ai, br, bi;
	assign ar = op.a_real[W-1:0];
	assign ai = op.a_imag[W-1:0];
	assign br = op.b_real[W-1:0];
	assign bi = op.b_imag[W-1:0];
	assign op.ready = en;

	cau_pkg::ctrl_t ctrl_s1, ctrl_s2;
	logic signed [W:0]    add_re_s1, add_im_s1, add_re_s2, add_im_s2;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1, p_bb_s1, p_cc_s1;
	logic signed [NW-1:0] num_re_s2, num_im_s2;
	logic [PW-1:0]        den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else if (en) begin
			ctrl_s1 <= '{valid: op.valid, cmd: cau_pkg::cmd_t'(op.command)};
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (cau_pkg::cmd_t'(op.command) == cau_pkg::CMD_SUB) begin
				add_re_s1 <= (W+1)'(ar) - (W+1)'(br);
				add_im_s1 <= (W+1)'(ai) - (W+1)'(bi);
			end else begin
				add_re_s1 <= (W+1)'(ar) + (W+1)'(br);
				add_im_s1 <= (W+1)'(ai) + (W+1)'(bi);
			end
			p_rr_s1 <= PW'(ar) * PW'(br);
			p_ii_s1 <= PW'(ai) * PW'(bi);
			p_ir_s1 <= PW'(ai) * PW'(br);
			p_ri_s1 <= PW'(ar) * PW'(bi);
			p_bb_s1 <= PW'(br) * PW'(br);
			p_cc_s1 <= PW'(bi) * PW'(bi);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			add_re_s2 <= add_re_s1;
			add_im_s2 <= add_im_s1;
			if (ctrl_s1.cmd == cau_pkg::CMD_DIV) begin
				num_re_s2 <= NW'(p_rr_s1) + NW'(p_ii_s1);
				num_im_s2 <= NW'(p_ir_s1) - NW'(p_ri_s1);
			end else begin
				num_re_s2 <= NW'(p_rr_s1) - NW'(p_ii_s1);
				num_im_s2 <= NW'(p_ir_s1) + NW'(p_ri_s1);
			end
			den_s2 <= $unsigned(p_bb_s1) + $unsigned(p_cc_s1);
		end
	end

	logic signed [XW-1:0] v_re, v_im;
	logic                 neg_re, neg_im, big_re, big_im, zero;
	logic [NW-1:0]        mag_re, mag_im;
	logic [RW-1:0]        n_re, n_im, den_w, den_top;

	always_comb begin
		if (ctrl_s2.cmd == cau_pkg::CMD_ADD || ctrl_s2.cmd == cau_pkg::CMD_SUB) begin
			v_re = XW'(add_re_s2);
			v_im = XW'(add_im_s2);
		end else begin
			v_re = XW'(num_re_s2 >>> F);
			v_im = XW'(num_im_s2 >>> F);
		end
		neg_re  = num_re_s2[NW-1];
		neg_im  = num_im_s2[NW-1];
		mag_re  = neg_re ? $unsigned(-num_re_s2) : $unsigned(num_re_s2);
		mag_im  = neg_im ? $unsigned(-num_im_s2) : $unsigned(num_im_s2);
		n_re    = RW'(mag_re) << F;
		n_im    = RW'(mag_im) << F;
		den_w   = RW'(den_s2);
		den_top = den_w << W;
		big_re  = n_re >= den_top;
		big_im  = n_im >= den_top;
		zero    = den_s2 == '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_re_s3 <= n_re;
			rem_im_s3 <= n_im;
			den_s3    <= den_w;
			side_s3   <= {clip(v_re), clip(v_im), ovf(v_re) | ovf(v_im), zero,
				neg_re, neg_im, big_re, big_im};
		end
	end
endmodule
`default_nettype wire

FILE: rtl/cau_div_step.sv
// One restoring-division stage: settles one quotient bit for both parts.
// Depends on cau_pkg.
`default_nettype none
module cau_div_step #(
	parameter int W    = cau_pkg::DATA_WIDTH_DEF,
	parameter int RW   = 3 * W + cau_pkg::FRAC_BITS_DEF + 1,
	parameter int STEP = 0,
	parameter int SW   = 2 * W + 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire cau_pkg::ctrl_t    prev_ctrl,
	input  wire logic [RW-1:0]     prev_rem_re,
	input  wire logic [RW-1:0]     prev_rem_im,
	input  wire logic [W-1:0]      prev_q_re,
	input  wire logic [W-1:0]      prev_q_im,
	input  wire logic [RW-1:0]     prev_den,
	input  wire logic [SW-1:0]     prev_side,
	output cau_pkg::ctrl_t         ctrl_s1,
	output logic [RW-1:0]          rem_re_s1,
	output logic [RW-1:0]          rem_im_s1,
	output logic [W-1:0]           q_re_s1,
	output logic [W-1:0]           q_im_s1,
	output logic [RW-1:0]          den_s1,
	output logic [SW-1:0]          side_s1
);
	logic [RW-1:0] dsh;
	logic [RW:0]   t_re, t_im;
	logic          ge_re, ge_im;
	logic [W-1:0]  qn_re, qn_im;

	always_comb begin
		dsh   = prev_den << STEP;
		t_re  = {1'b0, prev_rem_re} - {1'b0, dsh};
		t_im  = {1'b0, prev_rem_im} - {1'b0, dsh};
		ge_re = !t_re[RW];
		ge_im = !t_im[RW];
		qn_re = prev_q_re;
		qn_im = prev_q_im;
		qn_re[STEP] = ge_re;
		qn_im[STEP] = ge_im;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (en) begin
			ctrl_s1 <= prev_ctrl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_re_s1 <= ge_re ? t_re[RW-1:0] : prev_rem_re;
			rem_im_s1 <= ge_im ? t_im[RW-1:0] : prev_rem_im;
			q_re_s1   <= qn_re;
			q_im_s1   <= qn_im;
			den_s1    <= prev_den;
			side_s1   <= prev_side;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/cau_back.sv
// Result stage: quotient saturation, status, and the output register that
// drives the result channel and the pipeline enable. Depends on cau_pkg, cau_res_if.
`default_nettype none
module cau_back #(
	parameter int W  = cau_pkg::DATA_WIDTH_DEF,
	parameter int SW = 2 * W + 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cau_pkg::ctrl_t    prev_ctrl,
	input  wire logic [W-1:0]      prev_q_re,
	input  wire logic [W-1:0]      prev_q_im,
	input  wire logic [SW-1:0]     prev_side,
	output logic                   en,
	cau_res_if.source              res
);
	localparam logic [W-1:0] LIM  = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};

	logic [W-1:0] pre_re, pre_im;
	logic pre_sat, zero, neg_re, neg_im, big_re, big_im;
	assign {pre_re, pre_im, pre_sat, zero, neg_re, neg_im, big_re, big_im} = prev_side;

	logic                valid_q;
	logic signed [W-1:0] out_re_q, out_im_q;
	cau_pkg::status_t    status_q;
	cau_pkg::cmd_t       cmd_q;

	logic sat_re, sat_im;
	logic [W-1:0] d_re, d_im, f_re, f_im;
	cau_pkg::status_t st;

	always_comb begin
		sat_re = big_re || (neg_re ? (prev_q_re > LIM) : (prev_q_re > MAXW));
		sat_im = big_im || (neg_im ? (prev_q_im > LIM) : (prev_q_im > MAXW));
		d_re = neg_re ? (sat_re ? LIM : -prev_q_re) : (sat_re ? MAXW : prev_q_re);
		d_im = neg_im ? (sat_im ? LIM : -prev_q_im) : (sat_im ? MAXW : prev_q_im);
		if (prev_ctrl.cmd == cau_pkg::CMD_DIV) begin
			if (zero) begin
				f_re = '0;
				f_im = '0;
				st   = cau_pkg::ST_DZ;
			end else begin
				f_re = d_re;
				f_im = d_im;
				st   = (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
			end
		end else begin
			f_re = pre_re;
			f_im = pre_im;
			st   = pre_sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		end
	end

	assign en = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev_ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_re_q <= f_re;
			out_im_q <= f_im;
			status_q <= st;
			cmd_q    <= prev_ctrl.cmd;
		end
	end

	assign res.valid    = valid_q;
	assign res.out_real = cau_pkg::IO_WIDTH'(out_re_q);
	assign res.out_imag = cau_pkg::IO_WIDTH'(out_im_q);
	assign res.status   = status_q;

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && status_q == cau_pkg::ST_DZ |-> out_re_q == '0 && out_im_q == '0)
		else $error("divide-by-zero beat carries nonzero result");
	a_dz_div: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && status_q == cau_pkg::ST_DZ |-> cmd_q == cau_pkg::CMD_DIV)
		else $error("divide-by-zero status on non-divide beat");
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && status_q == cau_pkg::ST_SAT |->
		out_re_q == MAXW || out_re_q == LIM || out_im_q == MAXW || out_im_q == LIM)
		else $error("saturated status without a part at a rail");
endmodule
`default_nettype wire

FILE: dv/complex_arithmetic_unit_tb.sv
// Self-checking testbench for complex_arithmetic_unit: drives operand beats, predicts
// sum, difference, product and quotient with saturation, and checks each result beat.
// Depends on cau_pkg, cau_if and the RTL of the unit.
`default_nettype none
module complex_arithmetic_unit_tb;

	localparam int DW = cau_pkg::DATA_WIDTH_DEF;
	localparam int FB = cau_pkg::FRAC_BITS_DEF;

	typedef struct {
		logic signed [31:0] re;
		logic signed [31:0] im;
		cau_pkg::status_t   st;
	} cplx_res_t;

	int errors = 0;

	task automatic report(input string msg);
		$display("ERROR %s", msg);
		errors++;
	endtask

	function automatic logic signed [31:0] sat_part(input logic signed [127:0] v, ref bit flag);
		logic signed [127:0] hi;
		logic signed [127:0] lo;
		hi = (128'sd1 <<< (DW - 1)) - 1;
		lo = -(128'sd1 <<< (DW - 1));
		if (v > hi) begin
			flag = 1;
			return hi[31:0];
		end
		if (v < lo) begin
			flag = 1;
			return lo[31:0];
		end
		return v[31:0];
	endfunction

	function automatic logic signed [127:0] trunc_div(input logic signed [127:0] num,
			input logic signed [127:0] den);
		logic [127:0] mn;
		logic [127:0] q;
		mn = num < 0 ? -num : num;
		q = (mn << FB) / den;
		return num < 0 ? -$signed(q) : $signed(q);
	endfunction

	function automatic cplx_res_t predict_complex(input cau_pkg::cmd_t c,
			input logic signed [31:0] ar, input logic signed [31:0] ai,
			input logic signed [31:0] br, input logic signed [31:0] bi);
		cplx_res_t r;
		logic signed [127:0] a, b, x, y, d;
		bit flag;
		flag = 0;
		r.st = cau_pkg::ST_OK;
		a = ar;
		b = ai;
		x = 0;
		y = 0;
		d = 128'(br) * br + 128'(bi) * bi;
		case (c)
			cau_pkg::CMD_ADD: begin x = a + br; y = b + bi; end
			cau_pkg::CMD_SUB: begin x = a - br; y = b - bi; end
			cau_pkg::CMD_MUL: begin
				x = (a * br - b * bi) >>> FB;
				y = (b * br + a * bi) >>> FB;
			end
			default: begin
				if (d != 0) begin
					x = trunc_div(a * br + b * bi, d);
					y = trunc_div(b * br - a * bi, d);
				end
			end
		endcase
		r.re = sat_part(x, flag);
		r.im = sat_part(y, flag);
		if (c == cau_pkg::CMD_DIV && d == 0) r.st = cau_pkg::ST_DZ;
		else if (flag) r.st = cau_pkg::ST_SAT;
		return r;
	endfunction

	class result_scoreboard;
		cplx_res_t pending[$];

		function void note_operands(cau_pkg::cmd_t c, logic signed [31:0] ar,
				logic signed [31:0] ai, logic signed [31:0] br, logic signed [31:0] bi);
			pending.push_back(predict_complex(c, ar, ai, br, bi));
		endfunction

		task check_result(logic signed [31:0] re, logic signed [31:0] im, logic [1:0] st);
			cplx_res_t e;
			if (pending.size() == 0) begin
				report("result beat with nothing pending");
				return;
			end
			e = pending.pop_front();
			if (re !== e.re) report($sformatf("out_real %h expected %h", re, e.re));
			if (im !== e.im) report($sformatf("out_imag %h expected %h", im, e.im));
			if (st !== e.st) report($sformatf("status %0d expected %0d", st, e.st));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	cau_op_if  op ();
	cau_res_if res ();
	result_scoreboard sb = new();
	int send_idle = 22;
	int recv_idle = 59;
	bit hold_recv = 0;

	complex_arithmetic_unit dut (.clk(clk), .arst_n(arst_n), .op(op.sink), .res(res.source));

	always #1 clk = ~clk;

	initial begin
		op.valid = 0;
		op.command = 0;
		op.a_real = 0;
		op.a_imag = 0;
		op.b_real = 0;
		op.b_imag = 0;
		res.ready = 0;
	end

	always @(posedge clk) begin
		if (op.valid && op.ready)
			sb.note_operands(cau_pkg::cmd_t'(op.command), op.a_real, op.a_imag,
				op.b_real, op.b_imag);
		if (res.valid && res.ready) sb.check_result(res.out_real, res.out_imag, res.status);
	end

	always @(negedge clk) begin
		res.ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
	end

	function automatic logic [31:0] rand_field();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return 32'(signed'($urandom_range(131072)) - 65536);
			4: return 32'(signed'($urandom_range(16777216)) - 8388608);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_op(input cau_pkg::cmd_t c, input logic [31:0] ar,
			input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi);
		while ($urandom_range(99) < send_idle) begin
			op.valid <= 0;
			@(negedge clk);
		end
		op.valid <= 1;
		op.command <= c;
		op.a_real <= ar;
		op.a_imag <= ai;
		op.b_real <= br;
		op.b_imag <= bi;
		@(posedge clk);
		while (!op.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random(input int n);
		cau_pkg::cmd_t c;
		logic [31:0] bi;
		repeat (n) begin
			c = cau_pkg::cmd_t'($urandom_range(3));
			bi = rand_field();
			if (c == cau_pkg::CMD_DIV && $urandom_range(15) == 0)
				send_op(c, rand_field(), rand_field(), 0, 0);
			else
				send_op(c, rand_field(), rand_field(), rand_field(), bi);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		for (int c = 0; c < 4; c++) begin
			send_op(cau_pkg::cmd_t'(c), 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
				32'h8000_0000);
			send_op(cau_pkg::cmd_t'(c), 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000,
				32'hffff_0000);
			send_op(cau_pkg::cmd_t'(c), 32'h0001_8000, 32'hfffe_8000, 32'h0002_0000,
				32'h0000_4000);
			send_op(cau_pkg::cmd_t'(c), 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001,
				32'hffff_ffff);
			send_op(cau_pkg::cmd_t'(c), 32'h1234_5678, 32'hedcb_a987, 32'h0, 32'h0);
		end
		send_op(cau_pkg::CMD_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h1);
		send_op(cau_pkg::CMD_DIV, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000);
		send_random(270);
		fork
			begin
				hold_recv = 1;
				repeat (200) @(posedge clk);
				hold_recv = 0;
			end
			send_random(60);
		join
		send_idle = 59;
		recv_idle = 22;
		send_random(230);
		send_idle = 0;
		recv_idle = 0;
		send_random(220);
		op.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DW + 10) @(posedge clk);
		if (errors == 0) $display("PASS complex_arithmetic_unit");
		else $display("FAIL complex_arithmetic_unit");
		$finish;
	end

	initial begin
		#400000;
		$display("FAIL complex_arithmetic_unit");
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/cau_pkg.sv
rtl/cau_if.sv
rtl/cau_front.sv
rtl/cau_div_step.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
dv/complex_arithmetic_unit_tb.sv
